// File: rtl/rth_pkg.sv
// Shared types, widths and constants of the RGB to HSI pixel converter.
// Used by rth_cordic, rth_divider and rgb_to_hsi_pixel_unit; no dependencies.
package rth_pkg;

    localparam int TABLE_LEN = 24;
    localparam int XY_W      = 29;
    localparam int Z_W       = 27;
    localparam int NUM_W     = 27;
    localparam int DEN_W     = 11;
    localparam int QBITS     = 16;

    localparam logic [17:0]    SQRT3_Q16     = 18'd113512;
    localparam logic [Z_W-1:0] DEG180_Q16    = 27'd11796480;
    localparam logic [Z_W-1:0] DEG360_Q16    = 27'd23592960;
    localparam logic [14:0]    HUE_FULL_TURN = 15'd23040;
    localparam logic [18:0]    INV3_Q20      = 19'd349526;
    localparam logic [16:0]    SAT_SCALE2    = 17'd130560;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QBITS-1:0] nlo;
        logic [QBITS-1:0] q;
        logic [DEN_W-1:0] den;
    } t_div;

    function automatic logic [21:0] atan_q16(input int unsigned i);
        logic [21:0] v;
        case (i)
            0:       v = 22'd2949120;
            1:       v = 22'd1740967;
            2:       v = 22'd919879;
            3:       v = 22'd466945;
            4:       v = 22'd234379;
            5:       v = 22'd117304;
            6:       v = 22'd58666;
            7:       v = 22'd29335;
            8:       v = 22'd14668;
            9:       v = 22'd7334;
            10:      v = 22'd3667;
            11:      v = 22'd1833;
            12:      v = 22'd917;
            13:      v = 22'd458;
            14:      v = 22'd229;
            15:      v = 22'd115;
            16:      v = 22'd57;
            17:      v = 22'd29;
            18:      v = 22'd14;
            19:      v = 22'd7;
            20:      v = 22'd4;
            21:      v = 22'd2;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/rth_cordic.sv
// Vectoring CORDIC pipeline, one rotation in each of the first ITER_N register stages.
// Depends on rth_pkg for the state struct and the arctangent table.
module rth_cordic #(
    parameter int ITER_N = 16,
    parameter int DEPTH  = 16
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  rth_pkg::t_cordic i_data,
    output rth_pkg::t_cordic o_data
);

    rth_pkg::t_cordic r_st [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        rth_pkg::t_cordic w_in;
        rth_pkg::t_cordic n_st;

        if (k == 0) begin : g_first
            assign w_in = i_data;
        end else begin : g_next
            assign w_in = r_st[k-1];
        end

        if (k < ITER_N) begin : g_rot
            logic signed [rth_pkg::XY_W-1:0] dx;
            logic signed [rth_pkg::XY_W-1:0] dy;
            logic signed [rth_pkg::Z_W-1:0]  da;
            assign dx = w_in.x >>> k;
            assign dy = w_in.y >>> k;
            assign da = signed'({5'b0, rth_pkg::atan_q16(k)});
            always_comb begin
                if (!w_in.y[rth_pkg::XY_W-1]) begin
                    n_st.x = w_in.x + dy;
                    n_st.y = w_in.y - dx;
                    n_st.z = w_in.z + da;
                end else begin
                    n_st.x = w_in.x - dy;
                    n_st.y = w_in.y + dx;
                    n_st.z = w_in.z - da;
                end
            end
        end else begin : g_pass
            assign n_st = w_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_data = r_st[DEPTH-1];

endmodule

// File: rtl/rth_divider.sv
// Restoring divider pipeline, one quotient bit in each of the first QBITS register stages.
// Depends on rth_pkg for the divider state struct and widths.
module rth_divider #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  rth_pkg::t_div i_data,
    output rth_pkg::t_div o_data
);

    rth_pkg::t_div r_st [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        rth_pkg::t_div w_in;
        rth_pkg::t_div n_st;

        if (k == 0) begin : g_first
            assign w_in = i_data;
        end else begin : g_next
            assign w_in = r_st[k-1];
        end

        if (k < rth_pkg::QBITS) begin : g_bit
            logic [rth_pkg::DEN_W:0] t;
            logic                    ge;
            assign t  = {w_in.rem, w_in.nlo[rth_pkg::QBITS-1]};
            assign ge = (t >= {1'b0, w_in.den});
            always_comb begin
                n_st.den = w_in.den;
                n_st.nlo = {w_in.nlo[rth_pkg::QBITS-2:0], 1'b0};
                n_st.q   = {w_in.q[rth_pkg::QBITS-2:0], ge};
                if (ge) begin
                    n_st.rem = rth_pkg::DEN_W'(t - {1'b0, w_in.den});
                end else begin
                    n_st.rem = t[rth_pkg::DEN_W-1:0];
                end
            end
        end else begin : g_pass
            assign n_st = w_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_data = r_st[DEPTH-1];

endmodule

// File: rtl/rgb_to_hsi_pixel_unit.sv
// Top level of the RGB to HSI pixel converter: input, channel sum, setup and output stages.
// Depends on rth_pkg, rth_cordic and rth_divider.
//
// Usage:
//   Slave channel takes one RGB pixel per transfer; master channel returns
//   hue, saturation and intensity for it, in the same order.
//   Throughput is one pixel per cycle while the receiver does not stall,
//   set by the fully pipelined CORDIC and divider stages.
//   The whole pipeline advances together: when a result sits in the output
//   register and the receiver holds tready low, every stage holds and the
//   slave tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; data registers are not reset.
//   Hue is in 1/64 degree, saturation and intensity in Q8.8 on a 0..255
//   scale. Black and gray pixels give hue 0 and saturation 0.
module rgb_to_hsi_pixel_unit #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // hue[14:0], saturation[30:15],
                                          // intensity[46:31], zero[47]
);

    localparam int ITER_N = (ANGLE_ITERATIONS > rth_pkg::TABLE_LEN) ?
                            rth_pkg::TABLE_LEN : ANGLE_ITERATIONS;
    localparam int DEPTH  = (ITER_N > rth_pkg::QBITS) ? ITER_N : rth_pkg::QBITS;
    localparam int LAT    = DEPTH + 4;

    logic           ce;
    logic [LAT-1:0] r_vld;

    assign ce              = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // input stage
    logic [7:0] r_red, r_grn, r_blu;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_red <= i_s_axis_tdata[7:0];
            r_grn <= i_s_axis_tdata[15:8];
            r_blu <= i_s_axis_tdata[23:16];
        end
    end

    // channel sum, minimum and color differences
    logic [9:0]        n_sum, r_sum;
    logic [7:0]        n_mn, r_mn;
    logic signed [9:0] n_xi, r_xi;
    logic signed [8:0] n_yi, r_yi;
    logic              r_flag_b;

    always_comb begin
        n_sum = 10'(r_red) + 10'(r_grn) + 10'(r_blu);
        n_mn  = r_red;
        if (r_grn < n_mn) begin
            n_mn = r_grn;
        end
        if (r_blu < n_mn) begin
            n_mn = r_blu;
        end
        n_xi = signed'({1'b0, r_red, 1'b0}) - signed'({2'b0, r_grn})
             - signed'({2'b0, r_blu});
        n_yi = signed'({1'b0, r_grn}) - signed'({1'b0, r_blu});
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sum    <= n_sum;
            r_mn     <= n_mn;
            r_xi     <= n_xi;
            r_yi     <= n_yi;
            r_flag_b <= (n_sum != 10'(n_mn) * 10'd3);
        end
    end

    // setup of CORDIC, divider and intensity
    rth_pkg::t_cordic                n_cin, r_cin;
    rth_pkg::t_div                   n_din, r_din;
    logic signed [rth_pkg::XY_W-1:0] xs, ys;
    logic [9:0]                      diff;
    logic [rth_pkg::NUM_W-1:0]       num;
    logic [17:0]                     in3;
    logic [36:0]                     iprod;
    logic [15:0]                     r_int_c;
    logic                            r_flag_c;

    always_comb begin
        if (r_xi < 0) begin
            xs    = -rth_pkg::XY_W'(r_xi);
            ys    = -rth_pkg::XY_W'(r_yi);
            n_cin.z = signed'(rth_pkg::DEG180_Q16);
        end else begin
            xs    = rth_pkg::XY_W'(r_xi);
            ys    = rth_pkg::XY_W'(r_yi);
            n_cin.z = '0;
        end
        n_cin.x = xs <<< 16;
        n_cin.y = ys * signed'(rth_pkg::XY_W'(rth_pkg::SQRT3_Q16));

        diff  = r_sum - 10'(r_mn) * 10'd3;
        num   = rth_pkg::NUM_W'(rth_pkg::SAT_SCALE2) * rth_pkg::NUM_W'(diff)
              + rth_pkg::NUM_W'(r_sum);
        n_din.rem = num[rth_pkg::NUM_W-1:rth_pkg::QBITS];
        n_din.nlo = num[rth_pkg::QBITS-1:0];
        n_din.q   = '0;
        n_din.den = {r_sum, 1'b0};

        in3   = {r_sum, 8'd0} + 18'd1;
        iprod = 37'(in3) * 37'(rth_pkg::INV3_Q20);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cin    <= n_cin;
            r_din    <= n_din;
            r_int_c  <= iprod[35:20];
            r_flag_c <= r_flag_b;
        end
    end

    rth_pkg::t_cordic cout;
    rth_pkg::t_div    dout;

    rth_cordic #(.ITER_N(ITER_N), .DEPTH(DEPTH)) u_cordic (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_data (r_cin),
        .o_data (cout)
    );

    rth_divider #(.DEPTH(DEPTH)) u_divider (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_data (r_din),
        .o_data (dout)
    );

    // align intensity and chroma flag with the iterative units
    logic [15:0] r_idly [DEPTH];
    logic        r_fdly [DEPTH];
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_idly[0] <= r_int_c;
            r_fdly[0] <= r_flag_c;
            for (int k = 1; k < DEPTH; k++) begin
                r_idly[k] <= r_idly[k-1];
                r_fdly[k] <= r_fdly[k-1];
            end
        end
    end

    // wrap, round and output register
    logic [rth_pkg::Z_W-1:0] zw;
    logic [rth_pkg::Z_W-1:0] zr;
    logic [14:0]             hraw, n_hue, r_hue;
    logic [15:0]             n_sat, r_sat, r_inten;

    always_comb begin
        if (cout.z < 0) begin
            zw = rth_pkg::Z_W'(cout.z) + rth_pkg::DEG360_Q16;
        end else begin
            zw = rth_pkg::Z_W'(cout.z);
        end
        zr   = zw + rth_pkg::Z_W'(512);
        hraw = zr[24:10];
        if (!r_fdly[DEPTH-1] || hraw == rth_pkg::HUE_FULL_TURN) begin
            n_hue = '0;
        end else begin
            n_hue = hraw;
        end
        n_sat = r_fdly[DEPTH-1] ? dout.q : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_inten <= r_idly[DEPTH-1];
        end
    end

    assign o_m_axis_tdata = {1'b0, r_inten, r_sat, r_hue};

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_hue < rth_pkg::HUE_FULL_TURN))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_sat <= 16'd65280 && r_inten <= 16'd65280))
        else $error("saturation or intensity out of range");

    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_sat == 16'd0) |-> (r_hue == 15'd0))
        else $error("nonzero hue with zero saturation");

endmodule

// File: sim/rgb_to_hsi_pixel_unit_tb.sv
// Testbench for rgb_to_hsi_pixel_unit: drives RGB pixels over the slave stream and
// checks hue, saturation and intensity against an in-bench fixed-point predictor.
// Depends on rth_pkg and the RTL of the pixel converter.
`timescale 1ns / 1ps

module rgb_to_hsi_pixel_unit_tb;

    localparam int ITERS = 16;

    typedef struct packed {
        logic [15:0] inten;
        logic [15:0] sat;
        logic [14:0] hue;
    } t_hsi;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    t_hsi hsi_expected[$];
    int   fail_cnt;
    bit   rx_idle_en;
    bit   tx_idle_en;
    int   rx_hold_cycles;

    rgb_to_hsi_pixel_unit #(.ANGLE_ITERATIONS(ITERS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // red[7:0], green[15:8], blue[23:16]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // hue[14:0], saturation[30:15], intensity[46:31]
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -64'sd1 - ((-64'sd1 - v) >>> s);
    endfunction

    function automatic logic [14:0] hue_angle(longint xi, longint yi);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint h;
        int     n;
        x = xi * 65536;
        y = yi * 113512;
        z = 0;
        n = (ITERS > 24) ? 24 : ITERS;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 11796480;
        end
        for (int i = 0; i < n; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(rth_pkg::atan_q16(i));
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(rth_pkg::atan_q16(i));
            end
        end
        while (z < 0) z += 23592960;
        while (z >= 23592960) z -= 23592960;
        h = (z + 512) >>> 10;
        if (h >= 23040) h -= 23040;
        return h[14:0];
    endfunction

    function automatic t_hsi hsi_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_hsi    res;
        longint  sum;
        longint  mn;
        longint  num;
        sum = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res.inten = 16'((sum * 512 + 3) / 6);
        res.sat = '0;
        res.hue = '0;
        if (sum != 0 && sum != 3 * mn) begin
            num = 65280 * (sum - 3 * mn);
            res.sat = 16'((2 * num + sum) / (2 * sum));
            res.hue = hue_angle(2 * longint'(r) - g - b, longint'(g) - b);
        end
        return res;
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (tx_idle_en && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        hsi_expected.push_back(hsi_of(r, g, b));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (hsi_expected.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_idle_en && $urandom_range(99) < 15);
        end
    end

    always @(posedge i_clk) begin
        t_hsi got;
        t_hsi want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[46:0];
            if (hsi_expected.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                fail_cnt++;
            end else begin
                want = hsi_expected.pop_front();
                if (got.hue !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, got.hue);
                    fail_cnt++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturation: expected %0d, got %0d", want.sat, got.sat);
                    fail_cnt++;
                end
                if (got.inten !== want.inten) begin
                    $error("intensity: expected %0d, got %0d", want.inten, got.inten);
                    fail_cnt++;
                end
                if (m_tdata[47] !== 1'b0) begin
                    $error("pad: expected 0, got %b", m_tdata[47]);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd1, 8'd2, 8'd2);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0, 8'd128, 8'd127);
        drain();
    endtask

    task automatic test_random(int count);
        logic [7:0] c[3];
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: begin
                    c[0] = 8'($urandom_range(255));
                    c[1] = c[0];
                    c[2] = c[0];
                    c[2'($urandom_range(2))] = 8'($urandom_range(255));
                end
                1: foreach (c[k]) c[k] = $urandom_range(1) ? 8'd255 - 8'($urandom_range(3))
                                                        : 8'($urandom_range(3));
                default: foreach (c[k]) c[k] = 8'($urandom_range(255));
            endcase
            send_pixel(c[0], c[1], c[2]);
        end
    endtask

    task automatic test_back_pressure;
        @(posedge i_clk);
        rx_hold_cycles <= 80;
        test_random(60);
        drain();
    endtask

    initial begin
        fail_cnt = 0;
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        rx_hold_cycles = 0;
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300);
        drain();
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        test_random(850);
        drain();
        test_back_pressure();
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
